/* rtl/core/touch_panel_spi_reader_macros.svh */
// ----------------------------------------------------------------------------
// Touch panel SPI reader assertion macros
// Shared helpers for the concurrent checks on the block's ports.
// ----------------------------------------------------------------------------
`ifndef TOUCH_PANEL_SPI_READER_MACROS_SVH
`define TOUCH_PANEL_SPI_READER_MACROS_SVH

// Check a same-cycle implication, muted while reset is held.
`define TPSR_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("touch panel SPI reader check failed");

// Check an implication in the next cycle, muted while reset is held.
`define TPSR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("touch panel SPI reader check failed");

`endif

/* rtl/core/tpsr_pkg.sv */
// ----------------------------------------------------------------------------
// Touch panel SPI reader package
// Types, codes, widths and the command table shared by the block's files.
// ----------------------------------------------------------------------------
package tpsr_pkg;

    // Counter and field widths
    localparam int COUNT_WIDTH   = 32;
    localparam int OUT_COUNT_W   = 32;
    localparam int SAMPLE_W      = 12;
    localparam int PRESSURE_W    = 13;
    localparam int S_TDATA_W     = 8;
    localparam int M_TDATA_W     = 112;

    // Sequencer geometry: four frames of 24 bits each
    localparam int FRAME_IDX_W   = 5;
    localparam logic [FRAME_IDX_W-1:0] FRAME_LAST_IDX = 5'd23;
    localparam logic [FRAME_IDX_W-1:0] CMD_BITS       = 5'd8;
    localparam logic [1:0]             LAST_FRAME     = 2'd3;

    localparam logic [PRESSURE_W-1:0] PRESSURE_OFFSET = 13'd4095;
    localparam logic [PRESSURE_W-1:0] THRESHOLD_RESET = 13'd100;

    // Result field bit positions within m_tdata
    localparam int RES_CS_N_BIT    = 0;
    localparam int RES_SCLK_BIT    = 1;
    localparam int RES_MOSI_BIT    = 2;
    localparam int RES_BUSY_BIT    = 3;
    localparam int RES_DONE_BIT    = 4;
    localparam int RES_GRANTED_BIT = 5;
    localparam int RES_TOUCHED_BIT = 6;

    typedef enum logic [2:0] {
        OP_TICK         = 3'd0,
        OP_ACQUIRE      = 3'd1,
        OP_RELEASE      = 3'd2,
        OP_TOUCH_READ   = 3'd3,
        OP_DISPLAY_NOTE = 3'd4
    } opcode_t;

    typedef enum logic [1:0] {
        OWNER_NONE    = 2'd0,
        OWNER_DISPLAY = 2'd1,
        OWNER_TOUCH   = 2'd2,
        OWNER_STORAGE = 2'd3
    } owner_t;

    typedef logic [COUNT_WIDTH-1:0] count_t;

    typedef struct packed {
        opcode_t opcode;
        owner_t  owner;
        logic    miso;
        logic    irq_n;
    } tpsr_item_t;

    typedef struct packed {
        logic                   cs_n;
        logic                   sclk;
        logic                   mosi;
        logic                   busy;
        logic                   done;
        logic                   granted;
        logic                   touched;
        logic [SAMPLE_W-1:0]    raw_x;
        logic [SAMPLE_W-1:0]    raw_y;
        logic [PRESSURE_W-1:0]  pressure;
        logic [OUT_COUNT_W-1:0] violation_count;
        logic [OUT_COUNT_W-1:0] owner_transactions;
    } tpsr_result_t;

    // Command byte sent at the head of each frame
    function automatic logic [7:0] frame_cmd(input logic [1:0] frame);
        logic [7:0] cmd;
        case (frame)
            2'd0:    cmd = 8'hB1;
            2'd1:    cmd = 8'hC1;
            2'd2:    cmd = 8'hD1;
            default: cmd = 8'h91;
        endcase
        return cmd;
    endfunction

endpackage

/* rtl/core/touch_panel_spi_reader.sv */
// ----------------------------------------------------------------------------
// Touch panel SPI reader
// Shared SPI bus owner lock with a bit-level touch controller read sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Each s_ transaction is one tick: an opcode (tick, acquire, release, start
//   touch read, display note), an owner and the sampled miso and irq_n pins.
//   Each tick yields exactly one m_ transaction carrying the pin levels to
//   drive (cs_n, sclk, mosi), status flags, the held x, y and pressure
//   readings, the violation count and the named owner's transaction count.
//   A touch read runs 192 ticks after its start tick: 4 frames of 24 bits,
//   two ticks per bit; opcodes are ignored while it runs.
//   The user writes the pressure threshold on the cfg_ channel while idle;
//   the block does not enforce this. Throughput: one transaction per cycle
//   while m_tready is high, set by the input register feeding the result
//   register through one step of logic. When m_tready is low the result
//   holds and one more transaction is taken into the input register;
//   s_tready then drops until the result drains.
//   Reset (aresetn low, synchronous) frees the bus, clears all counters and
//   readings, stops any read and sets the threshold to 100.
// ----------------------------------------------------------------------------
module touch_panel_spi_reader (
    input  logic                              aclk,
    input  logic                              aresetn,
    // opcode[2:0], owner[4:3], miso[5], irq_n[6], zero[7]
    input  logic [tpsr_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // cs_n[0], sclk[1], mosi[2], busy_res[3], done_res[4], granted[5],
    // touched[6], raw_x[18:7], raw_y[30:19], pressure[43:31],
    // violation_count[75:44], owner_transactions[107:76], zero[111:108]
    output logic [tpsr_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [tpsr_pkg::PRESSURE_W-1:0]   cfg_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready
);
    import tpsr_pkg::*;

    logic                    in_valid_reg, in_valid_next;
    tpsr_item_t              in_item_reg;
    logic                    out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0]    out_data_reg;
    logic [PRESSURE_W-1:0]   threshold_reg;
    logic                    out_free, step_en, s_accept;
    tpsr_result_t            result;

    assign out_free  = !out_valid_reg || m_tready;
    assign step_en   = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Advance valid flags of both stages
    always_comb begin
        in_valid_next  = s_accept ? 1'b1 : (step_en ? 1'b0 : in_valid_reg);
        out_valid_next = step_en ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            threshold_reg <= THRESHOLD_RESET;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid) begin
                threshold_reg <= cfg_data;
            end
        end
    end

    // Capture the input transaction
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg.opcode <= opcode_t'(s_tdata[2:0]);
            in_item_reg.owner  <= owner_t'(s_tdata[4:3]);
            in_item_reg.miso   <= s_tdata[5];
            in_item_reg.irq_n  <= s_tdata[6];
        end
    end

    tpsr_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (step_en),
        .item      (in_item_reg),
        .threshold (threshold_reg),
        .result    (result)
    );

    // Pack the result into the output register
    always_ff @(posedge aclk) begin
        if (step_en) begin
            out_data_reg <= {4'b0000,
                             result.owner_transactions,
                             result.violation_count,
                             result.pressure,
                             result.raw_y,
                             result.raw_x,
                             result.touched,
                             result.granted,
                             result.done,
                             result.busy,
                             result.mosi,
                             result.sclk,
                             result.cs_n};
        end
    end

endmodule

/* rtl/core/tpsr_core.sv */
// ----------------------------------------------------------------------------
// Touch panel SPI reader core
// Bus owner lock, counters and the bit-level touch read sequencer; one
// transaction is processed per enabled cycle.
// ----------------------------------------------------------------------------
module tpsr_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              step_en,
    input  tpsr_pkg::tpsr_item_t              item,
    input  logic [tpsr_pkg::PRESSURE_W-1:0]   threshold,
    output tpsr_pkg::tpsr_result_t            result
);
    import tpsr_pkg::*;

    owner_t                   owner_reg,   owner_next;
    count_t                   viol_reg,    viol_next;
    count_t                   disp_reg,    disp_next;
    count_t                   touch_reg,   touch_next;
    count_t                   stor_reg,    stor_next;
    logic                     active_reg,  active_next;
    logic [1:0]               frame_reg,   frame_next;
    logic [FRAME_IDX_W-1:0]   idx_reg,     idx_next;
    logic                     half_reg,    half_next;
    logic [15:0]              shift_reg,   shift_next;
    logic [SAMPLE_W-1:0]      z1_reg,      z1_next;
    logic [SAMPLE_W-1:0]      z2_reg,      z2_next;
    logic [SAMPLE_W-1:0]      x_reg,       x_next;
    logic [SAMPLE_W-1:0]      y_reg,       y_next;
    logic [PRESSURE_W-1:0]    press_reg,   press_next;

    logic   sclk, mosi, done, granted, touched;
    count_t own_count;
    logic [7:0] cmd;

    // Next state and per-transaction flags
    always_comb begin
        owner_next  = owner_reg;
        viol_next   = viol_reg;
        disp_next   = disp_reg;
        touch_next  = touch_reg;
        stor_next   = stor_reg;
        active_next = active_reg;
        frame_next  = frame_reg;
        idx_next    = idx_reg;
        half_next   = half_reg;
        shift_next  = shift_reg;
        z1_next     = z1_reg;
        z2_next     = z2_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        press_next  = press_reg;
        sclk        = 1'b0;
        mosi        = 1'b0;
        done        = 1'b0;
        granted     = 1'b0;
        touched     = 1'b0;
        cmd         = frame_cmd(frame_reg);

        if (active_reg) begin
            // Drive the command bits, then zeros
            if (idx_reg < CMD_BITS) begin
                mosi = cmd[~idx_reg[2:0]];
            end
            if (!half_reg) begin
                sclk      = 1'b1;
                half_next = 1'b1;
            end else begin
                half_next  = 1'b0;
                shift_next = {shift_reg[14:0], item.miso};
                if (idx_reg == FRAME_LAST_IDX) begin
                    case (frame_reg)
                        2'd0:    z1_next = shift_next[14:3];
                        2'd1:    z2_next = shift_next[14:3];
                        2'd2:    x_next  = shift_next[14:3];
                        default: y_next  = shift_next[14:3];
                    endcase
                end
                if (idx_reg == FRAME_LAST_IDX && frame_reg == LAST_FRAME) begin
                    // Finish: free the bus and derive pressure
                    active_next = 1'b0;
                    frame_next  = 2'd0;
                    idx_next    = '0;
                    if (owner_reg != OWNER_TOUCH) begin
                        viol_next = viol_reg + 1'b1;
                    end
                    owner_next = OWNER_NONE;
                    if (z1_next > z2_next) begin
                        press_next = PRESSURE_W'(z1_next);
                    end else begin
                        press_next = PRESSURE_W'(z1_next) + PRESSURE_OFFSET
                                   - PRESSURE_W'(z2_next);
                    end
                    touched = !item.irq_n || (press_next > threshold);
                    done    = 1'b1;
                end else if (idx_reg == FRAME_LAST_IDX) begin
                    idx_next   = '0;
                    frame_next = frame_reg + 2'd1;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
        end else begin
            case (item.opcode)
                OP_ACQUIRE: begin
                    if (owner_reg != OWNER_NONE) begin
                        viol_next = viol_reg + 1'b1;
                    end else begin
                        owner_next = item.owner;
                        granted    = 1'b1;
                        case (item.owner)
                            OWNER_DISPLAY: disp_next  = disp_reg + 1'b1;
                            OWNER_TOUCH:   touch_next = touch_reg + 1'b1;
                            OWNER_STORAGE: stor_next  = stor_reg + 1'b1;
                            default:       ;
                        endcase
                    end
                end
                OP_RELEASE: begin
                    if (owner_reg != item.owner) begin
                        viol_next = viol_reg + 1'b1;
                    end
                    owner_next = OWNER_NONE;
                end
                OP_TOUCH_READ: begin
                    if (owner_reg != OWNER_NONE) begin
                        viol_next = viol_reg + 1'b1;
                        done      = 1'b1;
                    end else begin
                        owner_next  = OWNER_TOUCH;
                        touch_next  = touch_reg + 1'b1;
                        granted     = 1'b1;
                        active_next = 1'b1;
                        frame_next  = 2'd0;
                        idx_next    = '0;
                        half_next   = 1'b0;
                        shift_next  = '0;
                    end
                end
                OP_DISPLAY_NOTE: begin
                    // Acquire and release in one go; the bus stays free
                    if (owner_reg != OWNER_NONE) begin
                        viol_next = viol_reg + 1'b1;
                    end else begin
                        disp_next = disp_reg + 1'b1;
                        granted   = 1'b1;
                    end
                end
                default: ;
            endcase
        end

        case (item.owner)
            OWNER_DISPLAY: own_count = disp_next;
            OWNER_TOUCH:   own_count = touch_next;
            OWNER_STORAGE: own_count = stor_next;
            default:       own_count = '0;
        endcase
    end

    // Result of this transaction, taken after the state update
    always_comb begin
        result.cs_n               = !active_next;
        result.sclk               = sclk;
        result.mosi               = mosi;
        result.busy               = active_next;
        result.done               = done;
        result.granted            = granted;
        result.touched            = touched;
        result.raw_x              = x_next;
        result.raw_y              = y_next;
        result.pressure           = press_next;
        result.violation_count    = OUT_COUNT_W'(viol_next);
        result.owner_transactions = OUT_COUNT_W'(own_count);
    end

    // State registers, advanced once per processed transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            owner_reg  <= OWNER_NONE;
            viol_reg   <= '0;
            disp_reg   <= '0;
            touch_reg  <= '0;
            stor_reg   <= '0;
            active_reg <= 1'b0;
            frame_reg  <= '0;
            idx_reg    <= '0;
            half_reg   <= 1'b0;
            shift_reg  <= '0;
            z1_reg     <= '0;
            z2_reg     <= '0;
            x_reg      <= '0;
            y_reg      <= '0;
            press_reg  <= '0;
        end else if (step_en) begin
            owner_reg  <= owner_next;
            viol_reg   <= viol_next;
            disp_reg   <= disp_next;
            touch_reg  <= touch_next;
            stor_reg   <= stor_next;
            active_reg <= active_next;
            frame_reg  <= frame_next;
            idx_reg    <= idx_next;
            half_reg   <= half_next;
            shift_reg  <= shift_next;
            z1_reg     <= z1_next;
            z2_reg     <= z2_next;
            x_reg      <= x_next;
            y_reg      <= y_next;
            press_reg  <= press_next;
        end
    end

endmodule

/* rtl/core/tpsr_checker.sv */
// ----------------------------------------------------------------------------
// Touch panel SPI reader checker
// Port-level checks on result consistency, bound to the top level.
// ----------------------------------------------------------------------------
`include "touch_panel_spi_reader_macros.svh"

module tpsr_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic [tpsr_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic                            m_tvalid,
    input logic                            m_tready
);
    import tpsr_pkg::*;

    // Chip select is low exactly while a read runs
    `TPSR_ASSERT_SAME(a_cs_busy, aclk, aresetn, m_tvalid,
        m_tdata[RES_CS_N_BIT] != m_tdata[RES_BUSY_BIT])

    // Serial clock pulses only during a read
    `TPSR_ASSERT_SAME(a_sclk_busy, aclk, aresetn, m_tvalid && m_tdata[RES_SCLK_BIT],
        m_tdata[RES_BUSY_BIT])

    // A grant never coincides with a finished or refused read
    `TPSR_ASSERT_SAME(a_grant_done, aclk, aresetn, m_tvalid,
        !(m_tdata[RES_GRANTED_BIT] && m_tdata[RES_DONE_BIT]))

    // Touch reported only on a finishing tick
    `TPSR_ASSERT_SAME(a_touch_done, aclk, aresetn, m_tvalid && m_tdata[RES_TOUCHED_BIT],
        m_tdata[RES_DONE_BIT] && !m_tdata[RES_BUSY_BIT])

    // Hold a stalled result
    `TPSR_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata))

endmodule

bind touch_panel_spi_reader tpsr_checker u_tpsr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
